[sv/rpr_pkg.sv]
package rpr_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   // request kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   // widths fixed by the field list
   localparam int SAMPLE_W = 32;
   localparam int PCT_W    = 30;
   // dividend/divisor width for the percent-rank division
   localparam int DIV_W    = 52;

   // controller to datapath
   typedef struct packed {
      logic clear;       // empty the store
      logic append;      // write the request sample
      logic capture;     // latch query fields, reset scan
      logic scan;        // compare one stored sample
      logic prep;        // form span, offset and base count
      logic mul;         // form dividends and divisors
      logic div_start;   // load the divider
      logic div_step;    // one divider step
      logic finish;      // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;   // last scan read issued
      logic scan_empty;  // store holds no sample
      logic div_done;    // division finished
   } sts_type;

endpackage

[sv/rpr_ctrl.sv]
module rpr_ctrl
   import rpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic [1:0]    req_kind,
   input  logic          rsp_free,
   input  sts_type       sts,
   output cmd_type       cmd,
   output logic          busy
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCAN  = 8'b0000_0010,
      ST_DRAIN = 8'b0000_0100,
      ST_PREP  = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIVLD = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] drain_ff, drain_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  KIND_CLEAR:  cmd.clear = 1'b1;
                  KIND_APPEND: cmd.append = 1'b1;
                  KIND_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (sts.scan_empty) begin
               drain_in = 2'd0;
               state_in = ST_DRAIN;
            end else begin
               cmd.scan = 1'b1;
               if (sts.scan_last) begin
                  drain_in = 2'd2;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // let the read and compare pipeline empty
            cmd.scan = 1'b0;
            if (drain_ff == 2'd0) state_in = ST_PREP;
            else drain_in = drain_ff - 2'd1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIVLD;
         end
         ST_DIVLD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
            else cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

`ifndef ASSERT_OFF
   // one command at most in flight per cycle among the sequencing commands
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.append, cmd.capture, cmd.scan, cmd.prep, cmd.mul,
                cmd.div_start, cmd.div_step, cmd.finish}))
      else $error("more than one command");
   // a query capture always leads into the scan
   a_capture_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_SCAN)
      else $error("capture without scan");
   // the divider is loaded right after the multiply step
   a_mul_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.div_start)
      else $error("divider not loaded");
`endif

endmodule

[sv/rpr_data.sv]
module rpr_data
   import rpr_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic signed [SAMPLE_W-1:0]  req_x,
   input  logic                        req_desc,
   input  logic [3:0]                  req_sig,
   output sts_type                     sts,
   output logic                        r_rank_status,
   output logic [$clog2(CAPACITY+1):0] r_rank_equal,
   output logic [$clog2(CAPACITY+1)+1:0] r_rank_avg2,
   output logic                        r_inc_status,
   output logic [PCT_W-1:0]            r_inc,
   output logic                        r_exc_status,
   output logic [PCT_W-1:0]            r_exc,
   output logic                        r_ovf
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SW = SAMPLE_W + 1;

   // sample memory
   logic signed [SAMPLE_W-1:0] mem [CAPACITY];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic [CW-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;

   // query fields and scan
   logic signed [SAMPLE_W-1:0] x_ff;
   logic desc_ff;
   logic [3:0] sig_ff;
   logic [CW-1:0] addr_ff;
   logic rv_ff;       // read data valid
   logic [CW-1:0] less_ff, greater_ff, eq_ff, cntlo_ff;
   logic signed [SAMPLE_W-1:0] lo_ff, hi_ff;
   logic havelo_ff, havehi_ff;

   // prep and divider
   logic [SW-1:0] span_ff, d_ff;
   logic [CW-1:0] k_ff;
   logic [DIV_W-1:0] num_a_ff, den_a_ff, num_b_ff, den_b_ff;
   logic [DIV_W-1:0] rem_a_ff, rem_b_ff;
   logic [PCT_W-1:0] q_a_ff, q_b_ff;
   logic [3:0] digit_ff;
   logic [3:0] sub_ff;      // nonzero while a digit is being subtracted
   logic started_ff;

   assign count_in = cmd.clear ? '0 :
                     (cmd.append && count_ff != CW'(CAPACITY)) ? count_ff + 1'b1 : count_ff;
   assign ovf_in = cmd.clear ? 1'b0 :
                   (cmd.append && count_ff == CW'(CAPACITY)) ? 1'b1 : ovf_ff;

   // store write, store read
   always_ff @(posedge clock) begin
      if (cmd.append && count_ff != CW'(CAPACITY)) mem[count_ff[AW-1:0]] <= req_x;
      rd_ff <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= cmd.scan;
      end
   end

   assign sts.scan_empty = (count_ff == '0);
   assign sts.scan_last  = (addr_ff == count_ff - 1'b1);

   // scan compare, one sample a cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_x; desc_ff <= req_desc;
         sig_ff <= (req_sig == 4'd0) ? 4'd1 : (req_sig > 4'd9) ? 4'd9 : req_sig;
         addr_ff <= '0;
         less_ff <= '0; greater_ff <= '0; eq_ff <= '0; cntlo_ff <= '0;
         havelo_ff <= 1'b0; havehi_ff <= 1'b0;
      end else begin
         if (cmd.scan) addr_ff <= addr_ff + 1'b1;
         if (rv_ff) begin
            if (rd_ff < x_ff) begin
               less_ff <= less_ff + 1'b1;
               if (!havelo_ff || rd_ff > lo_ff) begin
                  lo_ff <= rd_ff; cntlo_ff <= CW'(1); havelo_ff <= 1'b1;
               end else if (rd_ff == lo_ff) cntlo_ff <= cntlo_ff + 1'b1;
            end else if (rd_ff > x_ff) begin
               greater_ff <= greater_ff + 1'b1;
               if (!havehi_ff || rd_ff < hi_ff) begin
                  hi_ff <= rd_ff; havehi_ff <= 1'b1;
               end
            end else eq_ff <= eq_ff + 1'b1;
         end
      end
   end

   logic in_range, exact;
   assign exact = (eq_ff != '0);
   assign in_range = exact || (havelo_ff && havehi_ff);

   // span and offset
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         span_ff <= SW'({hi_ff[SAMPLE_W-1], hi_ff}) - SW'({lo_ff[SAMPLE_W-1], lo_ff});
         d_ff    <= SW'({x_ff[SAMPLE_W-1], x_ff}) - SW'({lo_ff[SAMPLE_W-1], lo_ff});
         k_ff    <= less_ff - cntlo_ff;
      end
   end

   // dividends and divisors, one multiplier each
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         if (!in_range) begin
            // nothing to divide, the quotients stay zero
            num_a_ff <= '0;
            den_a_ff <= '0;
            num_b_ff <= '0;
            den_b_ff <= '0;
         end else if (exact) begin
            num_a_ff <= DIV_W'(less_ff);
            den_a_ff <= DIV_W'(count_ff - 1'b1);
            num_b_ff <= DIV_W'(less_ff) + 1'b1;
            den_b_ff <= DIV_W'(count_ff) + 1'b1;
         end else begin
            num_a_ff <= DIV_W'(k_ff) * DIV_W'(span_ff) + DIV_W'(d_ff);
            den_a_ff <= DIV_W'(span_ff) * DIV_W'(count_ff - 1'b1);
            num_b_ff <= (DIV_W'(k_ff) + 1'b1) * DIV_W'(span_ff) + DIV_W'(d_ff);
            den_b_ff <= DIV_W'(span_ff) * (DIV_W'(count_ff) + 1'b1);
         end
      end
   end

   // decimal long division by repeated subtraction; numerator <= divisor
   logic [DIV_W+2:0] ra10, rb10;
   logic ge_a, ge_b;
   assign ge_a = ({4'd0, rem_a_ff} >= {4'd0, den_a_ff}) && den_a_ff != '0;
   assign ge_b = ({4'd0, rem_b_ff} >= {4'd0, den_b_ff}) && den_b_ff != '0;
   assign ra10 = {rem_a_ff, 3'd0} + {2'd0, rem_a_ff, 1'b0};
   assign rb10 = {rem_b_ff, 3'd0} + {2'd0, rem_b_ff, 1'b0};
   assign sts.div_done = started_ff && (digit_ff == 4'd0) && (sub_ff == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (cmd.div_start) begin
         rem_a_ff <= num_a_ff; rem_b_ff <= num_b_ff;
         q_a_ff <= '0; q_b_ff <= '0;
         digit_ff <= sig_ff; sub_ff <= 4'd1;
         started_ff <= 1'b1;
      end else if (cmd.div_step) begin
         if (sub_ff != 4'd0) begin
            // subtract phase: at most 9 subtractions, quotient digit grows
            if (ge_a) begin
               rem_a_ff <= rem_a_ff - den_a_ff; q_a_ff <= q_a_ff + 1'b1;
            end
            if (ge_b) begin
               rem_b_ff <= rem_b_ff - den_b_ff; q_b_ff <= q_b_ff + 1'b1;
            end
            if (!ge_a && !ge_b) sub_ff <= 4'd0;
         end else begin
            // shift to next decimal digit
            rem_a_ff <= DIV_W'(ra10); rem_b_ff <= DIV_W'(rb10);
            q_a_ff <= PCT_W'({q_a_ff, 3'd0}) + PCT_W'({q_a_ff, 1'b0});
            q_b_ff <= PCT_W'({q_b_ff, 3'd0}) + PCT_W'({q_b_ff, 1'b0});
            digit_ff <= digit_ff - 1'b1;
            sub_ff <= 4'd10;
         end
      end else if (cmd.finish) begin
         started_ff <= 1'b0;
      end
   end

   // result fields
   logic [CW-1:0] better;
   assign better = desc_ff ? greater_ff : less_ff;
   assign r_rank_status = !exact;
   assign r_rank_equal  = exact ? (CW+1)'(better) + 1'b1 : '0;
   assign r_rank_avg2   = exact ? ((CW+2)'(better) << 1) + (CW+2)'(eq_ff) + 1'b1 : '0;
   assign r_inc_status  = (count_ff < CW'(2)) || !in_range;
   assign r_inc         = r_inc_status ? '0 : q_a_ff;
   assign r_exc_status  = (count_ff == '0) || !in_range;
   assign r_exc         = r_exc_status ? '0 : q_b_ff;
   assign r_ovf         = ovf_ff;

`ifndef ASSERT_OFF
   // the store never counts past its capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count beyond capacity");
   // overflow is only raised by an append on a full store
   a_ovf_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(cmd.append) && $past(count_ff) == CW'(CAPACITY))
      else $error("stray overflow");
   // a scan never reads beyond the filled part
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> addr_ff < count_ff)
      else $error("scan out of fill");
`endif

endmodule

[sv/rank_and_percentile_rank_unit.sv]
// channel  dir  signals                       contents
// req      in   req_tvalid/tready/tdata/tuser tdata: sample_or_x; tuser: kind,descending,sig
// rsp      out  rsp_tvalid/tready/tdata       rank, percent ranks and status
//
// clear and append give no response.
// a query compares one stored sample per cycle through the memory read port,
// then a decimal divider works out the percent ranks digit by digit, and the
// result goes to the response register as a valid response.
// reset is synchronous and empties the store; stored samples need no clearing.
// the response register holds a result while rsp_tready is low; a new
// request is taken once the previous result sits in the response register.
module rank_and_percentile_rank_unit
   import rpr_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_or_x
   input  logic [6:0]  req_tuser,   // [1:0] kind, [2] descending, [6:3] significance
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] rank_status, [11:1] rank_equal, [23:12] rank_average_doubled,
   // [24] inc_status, [54:25] percent_inc_scaled, [55] exc_status,
   // [85:56] percent_exc_scaled, [86] store_overflowed, [87] zero
   output logic [87:0] rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);

   cmd_type cmd;
   sts_type sts;
   logic busy, req_fire, rsp_free;
   logic r_rank_status;
   logic [CW:0] r_rank_equal;
   logic [CW+1:0] r_rank_avg2;
   logic r_inc_status, r_exc_status, r_ovf;
   logic [PCT_W-1:0] r_inc, r_exc;
   logic rsp_valid_ff;
   logic [87:0] rsp_data_ff;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   rpr_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_kind(req_tuser[1:0]), .rsp_free,
      .sts, .cmd, .busy
   );

   rpr_data #(.CAPACITY(CAPACITY)) u_data (
      .clock, .reset, .cmd,
      .req_x(req_tdata), .req_desc(req_tuser[2]), .req_sig(req_tuser[6:3]),
      .sts, .r_rank_status, .r_rank_equal, .r_rank_avg2,
      .r_inc_status, .r_inc, .r_exc_status, .r_exc, .r_ovf
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {1'b0, r_ovf, r_exc, r_exc_status, r_inc, r_inc_status,
                         12'(r_rank_avg2), 11'(r_rank_equal), r_rank_status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a response is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !cmd.finish)
      else $error("response overwritten");
   // no request is taken while a query runs
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("request while busy");
   // the padding bit stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87] == 1'b0)
      else $error("pad bit set");
`endif

endmodule

[verif/rpr_checker.sv]
module rpr_checker
   import rpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_or_x
   input  logic [6:0]  req_tuser,   // [1:0] kind, [2] descending, [6:3] significance
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,   // see the block's port list for the field layout
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bit               rank_status;
      logic [10:0]      rank_equal;
      logic [11:0]      rank_avg2;
      bit               inc_status;
      logic [PCT_W-1:0] pct_inc;
      bit               exc_status;
      logic [PCT_W-1:0] pct_exc;
      bit               overflowed;
   } rank_result_type;

   logic signed [SAMPLE_W-1:0] samples [CAPACITY_DEFAULT];
   int unsigned                sample_total;
   bit                         overflow_flag;
   rank_result_type            expected_ranks [$];

   // floor(a * 10^digits / b) by exact long division
   function automatic longint unsigned trunc_ratio(longint unsigned a, longint unsigned b,
                                                  int unsigned digits);
      longint unsigned q, r;
      if (b == 0) return 0;
      q = a / b;
      r = a % b;
      repeat (digits) begin
         r = r * 10;
         q = q * 10 + r / b;
         r = r % b;
      end
      return q;
   endfunction

   // rank and percent ranks of x against the current store
   function automatic rank_result_type rank_of(logic signed [31:0] x, bit desc,
                                               logic [3:0] sig);
      rank_result_type res;
      int unsigned     less, greater, eq, cnt_lo, better, digits, n;
      longint          v, lo, hi, xv;
      bit              have_lo, have_hi, in_range;
      longint unsigned span, offs, k;
      less = 0; greater = 0; eq = 0; cnt_lo = 0;
      have_lo = 0; have_hi = 0; lo = 0; hi = 0;
      span = 0; offs = 0; k = 0;
      xv = longint'(x);
      n = sample_total;
      digits = (sig < 1) ? 1 : (sig > 9) ? 9 : sig;
      for (int i = 0; i < n; i++) begin
         v = longint'(samples[i]);
         if (v < xv) begin
            less++;
            if (!have_lo || v > lo) begin
               lo = v; cnt_lo = 1; have_lo = 1;
            end else if (v == lo) begin
               cnt_lo++;
            end
         end else if (v > xv) begin
            greater++;
            if (!have_hi || v < hi) begin
               hi = v; have_hi = 1;
            end
         end else begin
            eq++;
         end
      end
      better = desc ? greater : less;
      in_range = (eq > 0) || (have_lo && have_hi);
      if (eq == 0 && in_range) begin
         span = longint'(hi - lo);
         offs = longint'(xv - lo);
         k = less - cnt_lo;
      end
      res = '{default: 0};
      res.overflowed = overflow_flag;
      // rank is only defined when x is stored
      if (eq == 0) begin
         res.rank_status = 1;
      end else begin
         res.rank_equal = 11'(better + 1);
         res.rank_avg2  = 12'(2 * better + eq + 1);
      end
      // inclusive percent rank
      if (n < 2 || !in_range) begin
         res.inc_status = 1;
      end else if (eq > 0) begin
         res.pct_inc = PCT_W'(trunc_ratio(less, n - 1, digits));
      end else begin
         res.pct_inc = PCT_W'(trunc_ratio(k * span + offs, span * (n - 1), digits));
      end
      // exclusive percent rank
      if (n < 1 || !in_range) begin
         res.exc_status = 1;
      end else if (eq > 0) begin
         res.pct_exc = PCT_W'(trunc_ratio(less + 1, n + 1, digits));
      end else begin
         res.pct_exc = PCT_W'(trunc_ratio((k + 1) * span + offs, span * (n + 1), digits));
      end
      return res;
   endfunction

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rank_result_type got, want;
      if (reset) begin
         sample_total = 0;
         overflow_flag = 0;
         expected_ranks.delete();
      end else begin
         // compare a delivered response with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.rank_status = rsp_tdata[0];
            got.rank_equal  = rsp_tdata[11:1];
            got.rank_avg2   = rsp_tdata[23:12];
            got.inc_status  = rsp_tdata[24];
            got.pct_inc     = rsp_tdata[54:25];
            got.exc_status  = rsp_tdata[55];
            got.pct_exc     = rsp_tdata[85:56];
            got.overflowed  = rsp_tdata[86];
            if (expected_ranks.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected response %h", $realtime, rsp_tdata);
            end else begin
               want = expected_ranks.pop_front();
               if (got != want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch exp rs=%0d eq=%0d avg2=%0d is=%0d inc=%0d ",
                               "es=%0d exc=%0d ov=%0d got rs=%0d eq=%0d avg2=%0d is=%0d ",
                               "inc=%0d es=%0d exc=%0d ov=%0d"}, $realtime,
                              want.rank_status, want.rank_equal, want.rank_avg2,
                              want.inc_status, want.pct_inc, want.exc_status,
                              want.pct_exc, want.overflowed,
                              got.rank_status, got.rank_equal, got.rank_avg2,
                              got.inc_status, got.pct_inc, got.exc_status,
                              got.pct_exc, got.overflowed);
               end
            end
         end
         // track the store and predict queries
         if (req_tvalid && req_tready) begin
            case (req_tuser[1:0])
               KIND_CLEAR: begin
                  sample_total = 0;
                  overflow_flag = 0;
               end
               KIND_APPEND: begin
                  if (sample_total < CAPACITY_DEFAULT) begin
                     samples[sample_total] = req_tdata;
                     sample_total++;
                  end else begin
                     overflow_flag = 1;
                  end
               end
               KIND_QUERY: begin
                  expected_ranks = {expected_ranks,
                                    rank_of(req_tdata, req_tuser[2], req_tuser[6:3])};
               end
               default: ;
            endcase
         end
      end
      pending_count = expected_ranks.size();
   end

endmodule

[verif/testbench.sv]
module testbench
   import rpr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] sample_or_x
   logic [6:0]  req_tuser;   // [1:0] kind, [2] descending, [6:3] significance
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // rank fields, percent ranks, status, overflow
   int          error_count;
   int          pending_count;

   bit          no_idle;      // stretch with no gaps on either side
   int          items_sent;
   logic [31:0] stored_vals [$];

   rank_and_percentile_rank_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   rpr_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side back-pressure
   initial begin
      int hold;
      rsp_tready = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else begin
            hold = pick_gap();
            rsp_tready <= (hold == 0);
         end
      end
   end

   // one request, entered and left at a falling edge
   task automatic send_req(logic [1:0] kind, logic [31:0] value, bit desc, logic [3:0] sig);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= value;
      req_tuser  <= {sig, desc, kind};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      if (kind == KIND_CLEAR) stored_vals.delete();
      if (kind == KIND_APPEND) stored_vals = {stored_vals, value};
   endtask

   task automatic query(logic [31:0] x);
      send_req(KIND_QUERY, x, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   // sample values: small integers with duplicates, fractions, or anything
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 3))
         0, 1: return 32'(($urandom_range(0, 12) - 6) * 65536);
         2: return 32'($urandom_range(0, 65535) - 32768);
         default: return $urandom;
      endcase
   endfunction

   // query values: mostly stored ones and their neighbors
   function automatic logic [31:0] pick_x();
      logic [31:0] v;
      if (stored_vals.size() == 0) return pick_sample();
      v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
      case ($urandom_range(0, 7))
         0, 1, 2: return v;
         3: return v + 1;
         4: return v - 1;
         5: return v + 32'h8000;
         6: return pick_sample();
         default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
   endfunction

   initial begin
      int n_app;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      no_idle = 0;
      items_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty store, single sample, extremes, duplicates, range edges
      send_req(KIND_QUERY, 32'h0, 0, 5);
      send_req(KIND_APPEND, 32'h7FFFFFFF, 0, 1);
      send_req(KIND_QUERY, 32'h7FFFFFFF, 0, 3);
      send_req(KIND_APPEND, 32'h80000000, 0, 1);
      send_req(KIND_APPEND, 32'h0, 0, 1);
      send_req(KIND_APPEND, 32'h0, 0, 1);
      send_req(KIND_APPEND, 32'h00030000, 0, 1);
      send_req(KIND_QUERY, 32'h0, 0, 9);
      send_req(KIND_QUERY, 32'h0, 1, 1);
      send_req(KIND_QUERY, 32'h00010000, 0, 6);
      send_req(KIND_QUERY, 32'h80000000, 1, 0);
      send_req(KIND_QUERY, 32'h7FFFFFFF, 0, 15);
      send_req(KIND_UNUSED, 32'hFFFFFFFF, 1, 15);
      send_req(KIND_CLEAR, 32'h0, 0, 0);
      send_req(KIND_APPEND, 32'h00050000, 0, 1);
      send_req(KIND_APPEND, 32'h00070000, 0, 1);
      send_req(KIND_QUERY, 32'h00010000, 0, 4);
      send_req(KIND_QUERY, 32'h00090000, 1, 4);
      send_req(KIND_QUERY, 32'h00060000, 0, 9);
      send_req(KIND_QUERY, 32'h00055555, 1, 7);
      // sender waits for every response
      req_tvalid <= 0;
      wait (pending_count == 0);
      @(negedge clock);

      // full store: fill to capacity and past it
      send_req(KIND_CLEAR, 32'h0, 0, 0);
      no_idle = 1;
      repeat (CAPACITY_DEFAULT + 2) send_req(KIND_APPEND, pick_sample(), 0, 1);
      no_idle = 0;
      repeat (3) query(pick_x());
      send_req(KIND_CLEAR, 32'h0, 0, 0);
      items_sent = 0;

      // random phases of an optional clear, appends, then queries
      while (items_sent < 540) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if (stored_vals.size() > 200 || $urandom_range(0, 9) < 6)
            send_req(KIND_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                     4'($urandom_range(0, 15)));
         n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
         repeat (n_app) begin
            send_req(KIND_APPEND, pick_sample(), 1'($urandom_range(0, 1)),
                     4'($urandom_range(0, 15)));
         end
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 19) == 0)
               send_req(KIND_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                        4'($urandom_range(0, 15)));
            query(pick_x());
         end
         if ($urandom_range(0, 9) == 0) begin
            req_tvalid <= 0;
            wait (pending_count == 0);
            @(negedge clock);
         end
      end
      req_tvalid <= 0;

      wait (pending_count == 0);
      repeat (1200) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
